[hdl/chod_pkg.sv]
// Shared types, constants and command/status structs for the online convex hull block.
// No dependencies; compiled first.
package chod_pkg;

  localparam int MAX_POINTS_DEF  = 63;
  localparam int DEQUE_DEPTH_DEF = 128;
  localparam int COORD_BITS_DEF  = 16;
  localparam int SEED_COUNT      = 3;

  // controller states
  typedef enum logic [4:0] {
    ST_IDLE, ST_DISPATCH,
    ST_SEED_MUL, ST_SEED_EV, ST_SEED_W0, ST_SEED_W1, ST_SEED_W2, ST_SEED_W3,
    ST_TB_RD, ST_TB_MUL, ST_TB_EV,
    ST_TT_RD, ST_TT_MUL, ST_TT_EV,
    ST_BP_RD, ST_BP_MUL, ST_BP_EV, ST_BP_WR,
    ST_TP_RD, ST_TP_MUL, ST_TP_EV, ST_TP_WR,
    ST_FIN, ST_OUT_RD, ST_OUT_SHOW
  } state_t;

  // deque read address selection
  typedef enum logic [1:0] {
    RD_BOT,   // bottom edge: b, nxt(b)
    RD_TOP,   // top edge: prv(t), t
    RD_OUT    // output walk pointer
  } rd_sel_t;

  // deque write selection
  typedef enum logic [1:0] {
    WR_AT_B,    // point at bottom index
    WR_AT_T,    // point at top index
    WR_SEED1,   // first seed slot of the triangle
    WR_SEED2    // second seed slot of the triangle
  } wr_sel_t;

  typedef struct packed {
    logic    ld_point;
    logic    seed_wr;
    logic    seed_latch;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    mul_en;
    logic    use_seed;
    logic    wr_en;
    wr_sel_t wr_sel;
    logic    init_idx;
    logic    b_inc;
    logic    b_dec;
    logic    t_inc;
    logic    t_dec;
    logic    cnt_inc;
    logic    ovf_set;
    logic    clear;
    logic    out_init;
    logic    out_next;
  } cmd_t;

  typedef struct packed {
    logic left_pos;
    logic cnt_full;
    logic cnt_lt2;
    logic cnt_eq2;
    logic cnt_gt3;
    logic b_meets_t;
    logic t_meets_b;
    logic out_last;
    logic final_flag;
  } status_t;

endpackage

[hdl/chod_if.sv]
// Valid/ready channel interfaces for input points and emitted hull vertices.
// Depends on nothing; parameterized by coordinate width.
interface chod_in_if #(parameter int COORD_BITS = 16);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic signed [COORD_BITS-1:0] point_z;
  logic                         final_point;

  modport source (output valid, point_x, point_y, point_z, final_point, input ready);
  modport sink   (input valid, point_x, point_y, point_z, final_point, output ready);
endinterface

interface chod_out_if #(parameter int COORD_BITS = 16);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] hull_x;
  logic signed [COORD_BITS-1:0] hull_y;
  logic signed [COORD_BITS-1:0] hull_z;
  logic                         end_of_hull;
  logic                         points_dropped;

  modport source (output valid, hull_x, hull_y, hull_z, end_of_hull, points_dropped,
                  input ready);
  modport sink   (input valid, hull_x, hull_y, hull_z, end_of_hull, points_dropped,
                  output ready);
endinterface

[hdl/chod_datapath.sv]
// Datapath: point and seed registers, deque memory, indices and orientation unit.
// Depends on chod_pkg for command/status structs and select codes.
module chod_datapath import chod_pkg::*; #(
  parameter int MAX_POINTS  = MAX_POINTS_DEF,
  parameter int DEQUE_DEPTH = DEQUE_DEPTH_DEF,
  parameter int COORD_BITS  = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  cmd_t                         cmd,
  output status_t                      sts,
  input  logic signed [COORD_BITS-1:0] in_x,
  input  logic signed [COORD_BITS-1:0] in_y,
  input  logic signed [COORD_BITS-1:0] in_z,
  input  logic                         in_final,
  output logic signed [COORD_BITS-1:0] out_x,
  output logic signed [COORD_BITS-1:0] out_y,
  output logic signed [COORD_BITS-1:0] out_z,
  output logic                         out_dropped
);

  localparam int IW      = $clog2(DEQUE_DEPTH);
  localparam int KW      = IW + 1;
  localparam int CW      = $clog2(MAX_POINTS + 1);
  localparam int DW      = 3 * COORD_BITS;
  localparam int MAX_RES = MAX_POINTS + 1;
  localparam int PW      = 2 * COORD_BITS + 2;

  typedef logic [IW-1:0] idx_t;

  function automatic idx_t nxt_f(idx_t i);
    return (i == IW'(DEQUE_DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  function automatic idx_t prv_f(idx_t i);
    return (i == '0) ? IW'(DEQUE_DEPTH - 1) : i - 1'b1;
  endfunction

  logic signed [COORD_BITS-1:0] px_r, py_r, pz_r;
  logic                         final_r;
  logic [DW-1:0]                s0_r, s1_r;
  logic                         seed_left_r;
  idx_t                         b_r, t_r, i_r;
  logic [CW-1:0]                cnt_r;
  logic [KW-1:0]                k_r;
  logic                         ovf_r;
  logic [DW-1:0]                mem [DEQUE_DEPTH];
  logic [DW-1:0]                rd0_r, rd1_r;
  logic signed [PW-1:0]         p1_r, p2_r;

  // point and seed capture
  always_ff @(posedge clk) begin
    if (cmd.ld_point) begin
      px_r    <= in_x;
      py_r    <= in_y;
      pz_r    <= in_z;
      final_r <= in_final;
    end
    if (cmd.seed_wr) begin
      if (cnt_r[0]) s1_r <= {px_r, py_r, pz_r};
      else          s0_r <= {px_r, py_r, pz_r};
    end
    if (cmd.seed_latch) seed_left_r <= sts.left_pos;
  end

  // indices, point count, overflow flag, output walk
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      b_r   <= '0;
      t_r   <= '0;
      cnt_r <= '0;
      ovf_r <= 1'b0;
      i_r   <= '0;
      k_r   <= '0;
    end else begin
      if (cmd.init_idx) begin
        b_r <= '0;
        t_r <= IW'(SEED_COUNT);
      end
      if (cmd.b_inc) b_r <= nxt_f(b_r);
      if (cmd.b_dec) b_r <= prv_f(b_r);
      if (cmd.t_inc) t_r <= nxt_f(t_r);
      if (cmd.t_dec) t_r <= prv_f(t_r);
      if (cmd.cnt_inc) cnt_r <= cnt_r + 1'b1;
      if (cmd.ovf_set) ovf_r <= 1'b1;
      if (cmd.out_init) begin
        i_r <= b_r;
        k_r <= '0;
      end
      if (cmd.out_next) begin
        i_r <= nxt_f(i_r);
        k_r <= k_r + 1'b1;
      end
    end
  end

  // read addresses
  idx_t ra0, ra1;
  always_comb begin
    unique case (cmd.rd_sel)
      RD_BOT:  begin ra0 = b_r;        ra1 = nxt_f(b_r); end
      RD_TOP:  begin ra0 = prv_f(t_r); ra1 = t_r;        end
      default: begin ra0 = i_r;        ra1 = i_r;        end
    endcase
  end

  // write address and data
  idx_t          wa;
  logic [DW-1:0] wd;
  always_comb begin
    unique case (cmd.wr_sel)
      WR_AT_B:  begin wa = b_r;     wd = {px_r, py_r, pz_r};           end
      WR_AT_T:  begin wa = t_r;     wd = {px_r, py_r, pz_r};           end
      WR_SEED1: begin wa = IW'(1);  wd = seed_left_r ? s0_r : s1_r;    end
      default:  begin wa = IW'(2);  wd = seed_left_r ? s1_r : s0_r;    end
    endcase
  end

  // deque memory: one write, two registered reads
  always_ff @(posedge clk) begin
    if (cmd.wr_en) mem[wa] <= wd;
    if (cmd.rd_en) begin
      rd0_r <= mem[ra0];
      rd1_r <= mem[ra1];
    end
  end

  // orientation: products registered, sign from compare next cycle
  logic [DW-1:0]              ea, eb;
  logic signed [COORD_BITS:0] dx1, dy1, dx2, dy2;
  always_comb begin
    ea  = cmd.use_seed ? s0_r : rd0_r;
    eb  = cmd.use_seed ? s1_r : rd1_r;
    dx1 = $signed({eb[DW-1], eb[DW-1 -: COORD_BITS]})
        - $signed({ea[DW-1], ea[DW-1 -: COORD_BITS]});
    dy1 = $signed({eb[DW-COORD_BITS-1], eb[DW-COORD_BITS-1 -: COORD_BITS]})
        - $signed({ea[DW-COORD_BITS-1], ea[DW-COORD_BITS-1 -: COORD_BITS]});
    dx2 = $signed({px_r[COORD_BITS-1], px_r})
        - $signed({ea[DW-1], ea[DW-1 -: COORD_BITS]});
    dy2 = $signed({py_r[COORD_BITS-1], py_r})
        - $signed({ea[DW-COORD_BITS-1], ea[DW-COORD_BITS-1 -: COORD_BITS]});
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      p1_r <= dx1 * dy2;
      p2_r <= dx2 * dy1;
    end
  end

  // hull span, capped at the result limit
  logic [KW-1:0] diff, span, span_cap;
  always_comb begin
    if (t_r >= b_r) diff = {1'b0, t_r} - {1'b0, b_r};
    else            diff = {1'b0, t_r} + KW'(DEQUE_DEPTH) - {1'b0, b_r};
    span = diff + 1'b1;
    if (32'(span) > 32'(MAX_RES)) span_cap = KW'(MAX_RES);
    else                          span_cap = span;
  end

  always_comb begin
    sts.left_pos   = p1_r > p2_r;
    sts.cnt_full   = cnt_r >= CW'(MAX_POINTS);
    sts.cnt_lt2    = cnt_r < CW'(2);
    sts.cnt_eq2    = cnt_r == CW'(2);
    sts.cnt_gt3    = cnt_r > CW'(SEED_COUNT);
    sts.b_meets_t  = nxt_f(b_r) == t_r;
    sts.t_meets_b  = prv_f(t_r) == b_r;
    sts.out_last   = (k_r + 1'b1) == span_cap;
    sts.final_flag = final_r;
  end

  assign out_x       = rd0_r[DW-1 -: COORD_BITS];
  assign out_y       = rd0_r[DW-COORD_BITS-1 -: COORD_BITS];
  assign out_z       = rd0_r[COORD_BITS-1:0];
  assign out_dropped = ovf_r;

endmodule

[hdl/chod_ctrl.sv]
// Controller state machine sequencing seeding, edge tests, pops, pushes and output.
// Depends on chod_pkg for the state enum and command/status structs.
module chod_ctrl import chod_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  logic    out_ready,
  input  status_t sts,
  output cmd_t    cmd,
  output logic    in_ready,
  output logic    out_valid
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:     if (in_valid) state_nxt = ST_DISPATCH;
      ST_DISPATCH: begin
        priority if (sts.cnt_full) state_nxt = ST_FIN;
        else if (sts.cnt_lt2)      state_nxt = ST_FIN;
        else if (sts.cnt_eq2)      state_nxt = ST_SEED_MUL;
        else                       state_nxt = ST_TB_RD;
      end
      ST_SEED_MUL: state_nxt = ST_SEED_EV;
      ST_SEED_EV:  state_nxt = ST_SEED_W0;
      ST_SEED_W0:  state_nxt = ST_SEED_W1;
      ST_SEED_W1:  state_nxt = ST_SEED_W2;
      ST_SEED_W2:  state_nxt = ST_SEED_W3;
      ST_SEED_W3:  state_nxt = ST_FIN;
      ST_TB_RD:    state_nxt = ST_TB_MUL;
      ST_TB_MUL:   state_nxt = ST_TB_EV;
      ST_TB_EV:    state_nxt = sts.left_pos ? ST_TT_RD : ST_BP_RD;
      ST_TT_RD:    state_nxt = ST_TT_MUL;
      ST_TT_MUL:   state_nxt = ST_TT_EV;
      ST_TT_EV:    state_nxt = sts.left_pos ? ST_FIN : ST_BP_RD;
      ST_BP_RD:    state_nxt = sts.b_meets_t ? ST_BP_WR : ST_BP_MUL;
      ST_BP_MUL:   state_nxt = ST_BP_EV;
      ST_BP_EV:    state_nxt = sts.left_pos ? ST_BP_WR : ST_BP_RD;
      ST_BP_WR:    state_nxt = ST_TP_RD;
      ST_TP_RD:    state_nxt = sts.t_meets_b ? ST_TP_WR : ST_TP_MUL;
      ST_TP_MUL:   state_nxt = ST_TP_EV;
      ST_TP_EV:    state_nxt = sts.left_pos ? ST_TP_WR : ST_TP_RD;
      ST_TP_WR:    state_nxt = ST_FIN;
      ST_FIN:      state_nxt = (sts.final_flag && sts.cnt_gt3) ? ST_OUT_RD : ST_IDLE;
      ST_OUT_RD:   state_nxt = ST_OUT_SHOW;
      ST_OUT_SHOW: begin
        if (out_ready) state_nxt = sts.out_last ? ST_IDLE : ST_OUT_RD;
      end
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd       = '0;
    cmd.rd_sel = RD_BOT;
    cmd.wr_sel = WR_AT_B;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready     = 1'b1;
        cmd.ld_point = in_valid;
      end
      ST_DISPATCH: begin
        priority if (sts.cnt_full) cmd.ovf_set = 1'b1;
        else if (sts.cnt_lt2) begin
          cmd.seed_wr = 1'b1;
          cmd.cnt_inc = 1'b1;
        end else cmd.cnt_inc = 1'b1;
      end
      ST_SEED_MUL: begin
        cmd.mul_en   = 1'b1;
        cmd.use_seed = 1'b1;
      end
      ST_SEED_EV: begin
        cmd.seed_latch = 1'b1;
        cmd.init_idx   = 1'b1;
      end
      ST_SEED_W0: begin cmd.wr_en = 1'b1; cmd.wr_sel = WR_AT_B;  end
      ST_SEED_W1: begin cmd.wr_en = 1'b1; cmd.wr_sel = WR_AT_T;  end
      ST_SEED_W2: begin cmd.wr_en = 1'b1; cmd.wr_sel = WR_SEED1; end
      ST_SEED_W3: begin cmd.wr_en = 1'b1; cmd.wr_sel = WR_SEED2; end
      ST_TB_RD:   begin cmd.rd_en = 1'b1; cmd.rd_sel = RD_BOT; end
      ST_TT_RD:   begin cmd.rd_en = 1'b1; cmd.rd_sel = RD_TOP; end
      ST_TB_MUL, ST_TT_MUL, ST_BP_MUL, ST_TP_MUL: cmd.mul_en = 1'b1;
      ST_BP_RD: begin
        if (sts.b_meets_t) cmd.b_dec = 1'b1;
        else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_BOT;
        end
      end
      ST_BP_EV: begin
        if (sts.left_pos) cmd.b_dec = 1'b1;
        else              cmd.b_inc = 1'b1;
      end
      ST_BP_WR: begin cmd.wr_en = 1'b1; cmd.wr_sel = WR_AT_B; end
      ST_TP_RD: begin
        if (sts.t_meets_b) cmd.t_inc = 1'b1;
        else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_TOP;
        end
      end
      ST_TP_EV: begin
        if (sts.left_pos) cmd.t_inc = 1'b1;
        else              cmd.t_dec = 1'b1;
      end
      ST_TP_WR: begin cmd.wr_en = 1'b1; cmd.wr_sel = WR_AT_T; end
      ST_FIN: begin
        if (sts.final_flag) begin
          if (sts.cnt_gt3) cmd.out_init = 1'b1;
          else             cmd.clear    = 1'b1;
        end
      end
      ST_OUT_RD: begin cmd.rd_en = 1'b1; cmd.rd_sel = RD_OUT; end
      ST_OUT_SHOW: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (sts.out_last) cmd.clear    = 1'b1;
          else              cmd.out_next = 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

[hdl/convex_hull_online_deque.sv]
// Top level of the online convex hull block: controller plus datapath.
// Depends on chod_pkg, chod_if, chod_ctrl and chod_datapath.
//
// Builds the convex hull of a simple polyline one vertex per input transaction with the
// deque scheme and, on the vertex marked final, emits the closed hull from bottom to top
// (first vertex repeated at the end); polylines of three or fewer vertices emit nothing.
// One vertex is handled at a time: the block is not ready for the next vertex until the
// current one has been seeded, dropped, tested or pushed, and a vertex that changes the
// hull pops entries from each end until a left turn or the two-entry floor; pops are amortized.
// Each edge test takes a registered deque read, registered products and a compare.
// Each hull vertex is read from the single deque memory through its registered read port
// and then offered on the output channel; vertices past MAX_POINTS are dropped and
// points_dropped is raised on every result of that run. The deque needs no clearing.
module convex_hull_online_deque import chod_pkg::*; #(
  parameter int MAX_POINTS  = MAX_POINTS_DEF,
  parameter int DEQUE_DEPTH = DEQUE_DEPTH_DEF,
  parameter int COORD_BITS  = COORD_BITS_DEF
) (
  input logic            clk,
  input logic            rst_n,
  chod_in_if.sink        in_if,
  chod_out_if.source     out_if
);

  cmd_t    cmd;
  status_t sts;

  chod_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .out_ready (out_if.ready),
    .sts       (sts),
    .cmd       (cmd),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid)
  );

  chod_datapath #(
    .MAX_POINTS  (MAX_POINTS),
    .DEQUE_DEPTH (DEQUE_DEPTH),
    .COORD_BITS  (COORD_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_x        (in_if.point_x),
    .in_y        (in_if.point_y),
    .in_z        (in_if.point_z),
    .in_final    (in_if.final_point),
    .out_x       (out_if.hull_x),
    .out_y       (out_if.hull_y),
    .out_z       (out_if.hull_z),
    .out_dropped (out_if.points_dropped)
  );

  assign out_if.end_of_hull = sts.out_last;

endmodule

[hdl/chod_checker.sv]
// Port-level checker for the online convex hull block, bound to the top level.
// Depends on nothing but the top level's channel signals.
module chod_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_x,
  input logic out_end,
  input logic out_dropped
);

  // input is never taken while a hull vertex is on offer
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while output valid");

  // an accepted input transaction leaves the block busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after accepting a vertex");

  // a stalled hull vertex keeps valid, bit 0 of its x coordinate and the end flag
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_end))
    else $error("stalled output changed");

  // after the closing vertex the block is ready for a new polyline
  a_ready_after_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_end |=> in_ready)
    else $error("not ready after hull run");

  // drop flag is constant across one hull run
  a_drop_steady: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_end |-> ##2 (out_valid && out_dropped == $past(out_dropped, 2)))
    else $error("drop flag changed within run");

endmodule

bind convex_hull_online_deque chod_checker u_chod_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_if.valid),
  .in_ready    (in_if.ready),
  .out_valid   (out_if.valid),
  .out_ready   (out_if.ready),
  .out_x       (out_if.hull_x[0]),
  .out_end     (out_if.end_of_hull),
  .out_dropped (out_if.points_dropped)
);
